// ===== src/lkt_pkg.sv =====
// ============================================================================
// lkt_pkg: shared constants and types for the LRU key table
// Port-level field widths, the configuration register map and the result
// record passed from the table logic to the output stage.
// ============================================================================
package lkt_pkg;

  // Default sizing of the table
  localparam int DEFAULT_DEPTH    = 16;
  localparam int DEFAULT_KEY_BITS = 32;

  // Fixed field widths on the ports
  localparam int REQ_KEY_W = 32;
  localparam int SLOT_W    = 4;
  localparam int EVK_W     = 32;

  // Configuration port
  localparam int                CAP_W       = 5;
  localparam int                APB_ADDR_W  = 3;
  localparam int                APB_DATA_W  = 32;
  localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
  // register index taken from the word address bit
  localparam logic              REG_CAPACITY = 1'b0;

  // One lookup result
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [EVK_W-1:0]  evicted_key;
  } result_t;

endpackage

// ===== src/lkt_table.sv =====
// ============================================================================
// lkt_table: key store, valid marks and recency ranks
// Parallel compare of one key against all entries, choice of the target slot
// (hit, free slot or oldest entry) and the state update for one request.
// ============================================================================
module lkt_table #(
  parameter int DEPTH    = lkt_pkg::DEFAULT_DEPTH,
  parameter int KEY_BITS = lkt_pkg::DEFAULT_KEY_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,      // commit the request's update
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [lkt_pkg::CAP_W-1:0] cap_i,
  output lkt_pkg::result_t         res_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int EW    = (OCC_W > lkt_pkg::CAP_W) ? OCC_W : lkt_pkg::CAP_W;

  logic [KEY_BITS-1:0] key_q  [DEPTH];
  logic [IDX_W-1:0]    rank_q [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [OCC_W-1:0]    occ_q;

  logic [DEPTH-1:0]    match_vec;
  logic [DEPTH-1:0]    free_vec;
  logic [DEPTH-1:0]    free_oh;
  logic [DEPTH-1:0]    oldest_vec;
  logic [DEPTH-1:0]    tgt_oh;
  logic [IDX_W-1:0]    tgt_idx;
  logic [IDX_W-1:0]    hit_rank;
  logic [KEY_BITS-1:0] old_key;
  logic [OCC_W-1:0]    occ_last;
  logic                hit;
  logic                insert;
  logic [EW-1:0]       cap_x;
  logic [EW-1:0]       eff_cap;

  // Effective capacity: zero acts as one, clipped to the table depth
  always_comb begin
    cap_x = EW'(cap_i);
    if (cap_x == '0) begin
      eff_cap = EW'(1);
    end else if (cap_x > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_x;
    end
  end

  // Per-entry compares; valid ranks are always 0..occ-1, so the oldest
  // entry is the one ranked occ-1
  assign occ_last = occ_q - OCC_W'(1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i]  = valid_q[i] && (key_q[i] == key_i);
      oldest_vec[i] = valid_q[i] && (OCC_W'(rank_q[i]) == occ_last);
    end
  end

  // Lowest free slot
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + DEPTH'(1));

  assign hit    = |match_vec;
  assign insert = !hit && (EW'(occ_q) < eff_cap);

  always_comb begin
    if (hit) begin
      tgt_oh = match_vec;
    end else if (insert) begin
      tgt_oh = free_oh;
    end else begin
      tgt_oh = oldest_vec;
    end
  end

  // One-hot selects: slot index, rank of the hit entry, replaced key
  always_comb begin
    tgt_idx  = '0;
    hit_rank = '0;
    old_key  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tgt_oh[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
      if (match_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
      if (oldest_vec[i]) begin
        old_key = old_key | key_q[i];
      end
    end
  end

  always_comb begin
    res_o.hit         = hit;
    res_o.slot        = lkt_pkg::SLOT_W'(tgt_idx);
    res_o.evicted     = !hit && !insert;
    res_o.evicted_key = (!hit && !insert) ? lkt_pkg::EVK_W'(old_key) : '0;
  end

  // Valid marks, ranks and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (upd_i) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tgt_oh[i]) begin
          rank_q[i]  <= '0;
          valid_q[i] <= 1'b1;
        end else if (valid_q[i] && (!hit || (rank_q[i] < hit_rank))) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
      if (insert) begin
        occ_q <= occ_q + OCC_W'(1);
      end
    end
  end

  // Key store, written on insert or replace
  always_ff @(posedge clk_i) begin
    if (upd_i && !hit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tgt_oh[i]) begin
          key_q[i] <= key_i;
        end
      end
    end
  end

endmodule

// ===== src/lru_key_table.sv =====
// ============================================================================
// lru_key_table: fully associative key table with LRU replacement
// Looks up one key per request, reports hit and slot, and on a full table
// replaces the least recent entry and reports its key.
// ============================================================================
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata[31:0] request_key
//  m_axis    out        tdata[3:0] slot, [35:4] evicted_key; tuser[0] hit,
//                       tuser[1] evicted
//  apb       in/out     reg 0 @ 0x0: capacity[4:0]
//
//  One request per cycle sustained while m_axis does not stall; a request
//  passes the input register, then the result register. The compare, slot
//  choice and table update happen combinationally between the two registers.
//  Reset clears all valid marks, ranks and occupancy at once; capacity
//  resets to 16. A stall on m_axis holds the result register; tready drops
//  once the input register is full as well.
//
module lru_key_table #(
  parameter int DEPTH    = lkt_pkg::DEFAULT_DEPTH,
  parameter int KEY_BITS = lkt_pkg::DEFAULT_KEY_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lkt_pkg::REQ_KEY_W-1:0]     s_axis_tdata,   // [31:0] request_key
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,   // [3:0] slot, [35:4] evicted_key
  output logic [1:0]                        m_axis_tuser,   // [0] hit, [1] evicted
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkt_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lkt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lkt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic                              in_v_q, in_v_d;
  logic [lkt_pkg::REQ_KEY_W-1:0]     in_key_q;
  logic                              out_v_q, out_v_d;
  lkt_pkg::result_t                  out_res_q;
  lkt_pkg::result_t                  res;
  logic [lkt_pkg::CAP_W-1:0]         cap_q;
  logic                              advance;
  logic                              in_take;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkt_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == lkt_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[lkt_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      lkt_pkg::REG_CAPACITY: prdata = lkt_pkg::APB_DATA_W'(cap_q);
      default:               prdata = '0;
    endcase
  end

  // Handshake: both registers move when the result register is free
  assign advance       = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_take) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end else begin
      in_v_d = in_v_q;
    end
    out_v_d = advance ? in_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_key_q <= s_axis_tdata;
    end
    if (advance && in_v_q) begin
      out_res_q <= res;
    end
  end

  // Table lookup and update
  lkt_table #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance && in_v_q),
    .key_i  (KEY_BITS'(in_key_q)),
    .cap_i  (cap_q),
    .res_o  (res)
  );

  // Result stream
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, out_res_q.evicted_key, out_res_q.slot};
  assign m_axis_tuser  = {out_res_q.evicted, out_res_q.hit};

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb: self-checking testbench for lru_key_table
// Streams key lookups into the table while the result side stalls at random.
// A behavioral LRU table in the bench predicts hit, slot and eviction for
// every accepted request. Capacity is reprogrammed over APB between phases,
// including zero, values above the table depth and values below occupancy.
// ============================================================================
`timescale 1ns / 100ps

module tb;

  localparam int          TBL_DEPTH     = lkt_pkg::DEFAULT_DEPTH;
  localparam int          RANDOM_ITEMS  = 1050;
  // register map
  localparam logic [lkt_pkg::APB_ADDR_W-1:0] CAPACITY_ADDR = 3'd0;
  localparam logic [lkt_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] request_key
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [3:0] slot, [35:4] evicted_key
  logic [1:0]  m_axis_tuser;   // [0] hit, [1] evicted
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [lkt_pkg::APB_ADDR_W-1:0] paddr;
  logic [lkt_pkg::APB_DATA_W-1:0] pwdata;
  logic [lkt_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  // shadow LRU table
  logic [31:0] tbl_key   [TBL_DEPTH];
  bit          tbl_valid [TBL_DEPTH] = '{default: 1'b0};
  int          tbl_rank  [TBL_DEPTH] = '{default: 0};
  int          tbl_occ   = 0;
  logic [4:0]  cap_reg   = lkt_pkg::CAP_RESET;

  lkt_pkg::result_t pending_results[$];
  int               errors = 0;
  bit               steady = 1'b0;   // no gaps and no stalls while set
  int               stall_left = 0;

  lru_key_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // ------------------------------------------------------------------
  // Shadow table
  // ------------------------------------------------------------------

  // every valid entry more recent than limit gets one step older
  function automatic void age_entries(input int limit);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_rank[i] < limit) tbl_rank[i]++;
    end
  endfunction

  function automatic lkt_pkg::result_t lru_lookup(input logic [31:0] key);
    lkt_pkg::result_t res;
    int  s;
    int  oldest;
    int  eff_cap;
    bit  found;
    bit  any;
    res     = '0;
    s       = 0;
    found   = 1'b0;
    eff_cap = (cap_reg == 0) ? 1 : (cap_reg > TBL_DEPTH) ? TBL_DEPTH : int'(cap_reg);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (!found && tbl_valid[i] && tbl_key[i] == key) begin
        s     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      age_entries(tbl_rank[s]);
      tbl_rank[s] = 0;
    end else if (tbl_occ < eff_cap && tbl_occ < TBL_DEPTH) begin
      // lowest free slot
      any = 1'b0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (!any && !tbl_valid[i]) begin
          s   = i;
          any = 1'b1;
        end
      end
      age_entries(TBL_DEPTH);
      tbl_valid[s] = 1'b1;
      tbl_key[s]   = key;
      tbl_rank[s]  = 0;
      tbl_occ++;
    end else begin
      // replace the least recent valid entry, lowest slot on a tie
      any    = 1'b0;
      oldest = 0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (tbl_valid[i] && (!any || tbl_rank[i] > oldest)) begin
          oldest = tbl_rank[i];
          s      = i;
          any    = 1'b1;
        end
      end
      res.evicted     = any;
      res.evicted_key = any ? tbl_key[s] : '0;
      age_entries(oldest);
      if (!any) begin
        tbl_valid[s] = 1'b1;
        tbl_occ++;
      end
      tbl_key[s]  = key;
      tbl_rank[s] = 0;
    end
    res.hit  = found;
    res.slot = s[3:0];
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one lookup request; the expectation is computed at acceptance
  task automatic send_key(input logic [31:0] key);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(lru_lookup(key));
  endtask

  // stop requests and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write, only issued with the table idle
  task automatic write_reg(input logic [lkt_pkg::APB_ADDR_W-1:0] addr,
                           input logic [4:0] value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {27'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == CAPACITY_ADDR) cap_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 80) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    lkt_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata=%h tuser=%b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata[3:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tdata[35:4] !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key,
                 m_axis_tdata[35:4]);
          errors++;
        end
        if (m_axis_tdata[39:36] !== 4'd0) begin
          $error("tdata padding: expected %h, got %h", 4'd0, m_axis_tdata[39:36]);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // reset capacity: extreme keys, hit on an older entry, hit on the newest
  task automatic test_hit_order();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
  endtask

  // capacity zero, above depth, unmapped write, and lowering below occupancy
  task automatic test_capacity_edges();
    write_reg(CAPACITY_ADDR, 5'd0);      // acts as one entry
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    write_reg(CAPACITY_ADDR, 5'd31);     // clamps to the table depth
    send_key(32'h8000_0001);
    send_key(32'h7FFF_FFFE);
    send_key(32'h0F0F_F0F0);
    write_reg(UNMAPPED_ADDR, 5'd1);      // must not touch capacity
    send_key(32'h1234_5678);
    send_key(32'hEDCB_A987);
    write_reg(CAPACITY_ADDR, 5'd3);      // below occupancy: replace only
    send_key(32'hC0DE_0001);
    send_key(32'hC0DE_0002);
    send_key(32'hEDCB_A987);
    write_reg(CAPACITY_ADDR, 5'd1);
    send_key(32'hC0DE_0002);
    send_key(32'h0000_0001);
  endtask

  // phases with different capacities and key pools sized around them
  task automatic test_random_traffic();
    logic [31:0] pool[$];
    logic [31:0] key;
    logic [4:0]  caps[$];
    int          eff;
    int          per_phase;
    int          sent;
    caps      = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd15};
    per_phase = 88;
    sent      = 0;
    while (sent < RANDOM_ITEMS) begin
      if (caps.size() != 0) write_reg(CAPACITY_ADDR, caps.pop_front());
      else write_reg(CAPACITY_ADDR, 5'($urandom_range(0, 31)));
      eff    = (cap_reg == 0) ? 1 : (cap_reg > TBL_DEPTH) ? TBL_DEPTH : int'(cap_reg);
      steady = ($urandom_range(0, 3) == 0);
      pool.delete();
      repeat (eff + $urandom_range(0, 6)) pool.push_back($urandom());
      if ($urandom_range(0, 1)) pool.push_back(32'h0000_0000);
      if ($urandom_range(0, 1)) pool.push_back(32'hFFFF_FFFF);
      repeat (per_phase) begin
        if ($urandom_range(0, 9) == 0) key = $urandom();
        else key = pool[$urandom_range(0, pool.size() - 1)];
        send_key(key);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_hit_order();
    test_capacity_edges();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
